[rtl/pitd_pkg.sv]
package pitd_pkg;

  // default field width limit, and width of every width/pad counter (holds up to 63)
  localparam int unsigned MaxWidthDef = 31;
  localparam int unsigned CntW        = 6;

  // number of decimal digits of a 32-bit magnitude
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigCntW   = 4;

  // descriptor queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // size modifier codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  // pad flag codes
  localparam logic [1:0] PAD_ZERO  = 2'd1;
  localparam logic [1:0] PAD_SPACE = 2'd2;

  // ascii characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // fixed-point reciprocal of ten, used with a right shift of 35
  localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  // one converted number, ready to be written out
  typedef struct packed {
    logic                 neg;
    logic                 sign_en;
    logic                 pad_zero;
    logic [CntW-1:0]      pad_cnt;
    logic [DigCntW-1:0]   nd;
    digits_t              digits;  // index 0 is the most significant digit
  } desc_t;

endpackage

[rtl/pitd_fifo.sv]
module pitd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pitd_pkg::desc_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output pitd_pkg::desc_t rdata_o,
  output logic            empty_o
);
  import pitd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);

  desc_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntQW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/pitd_front.sv]
module pitd_front #(
  parameter int unsigned MAX_WIDTH = pitd_pkg::MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [31:0]     arg_value_i,
  input  logic            signed_conv_i,
  input  logic [1:0]      size_mode_i,
  input  logic [1:0]      pad_mode_i,
  input  logic [7:0]      min_width_i,
  output logic            q_push_o,
  output pitd_pkg::desc_t q_data_o,
  input  logic            q_full_i
);
  import pitd_pkg::*;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_CONV = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [31:0]        mag_q;
  digits_t            digits_q;
  logic [DigCntW-1:0] nd_q;
  logic               neg_q, sign_en_q, pad_zero_q;
  logic [CntW-1:0]    w_q;

  logic [31:0]        ext;
  logic               neg;
  logic               sign_en;
  logic [31:0]        mag_in;
  logic [CntW-1:0]    w_clamp, w_in;
  logic [63:0]        prod;
  logic [31:0]        quot;
  logic [31:0]        quot_x10;
  logic [31:0]        rem_full;
  logic               accept;

  // narrow and extend the argument
  always_comb begin
    unique case (size_mode_i)
      SIZE_8:  ext = {{24{signed_conv_i & arg_value_i[7]}}, arg_value_i[7:0]};
      SIZE_16: ext = {{16{signed_conv_i & arg_value_i[15]}}, arg_value_i[15:0]};
      default: ext = arg_value_i;
    endcase
  end

  assign neg     = signed_conv_i & ext[31];
  assign mag_in  = neg ? (32'd0 - ext) : ext;
  assign sign_en = neg | (signed_conv_i & (pad_mode_i == PAD_SPACE));

  assign w_clamp = (min_width_i > 8'(MAX_WIDTH)) ? CntW'(MAX_WIDTH) : CntW'(min_width_i);
  // sign character takes one column, saturating at zero
  assign w_in    = (sign_en && (w_clamp != '0)) ? w_clamp - 1'b1 : w_clamp;

  // one digit per cycle: quotient by reciprocal multiply, remainder by shift-add
  assign prod     = {32'd0, mag_q} * {32'd0, RECIP_TEN};
  assign quot     = {3'd0, prod[63:35]};
  assign quot_x10 = {quot[28:0], 3'd0} + {quot[30:0], 1'b0};
  assign rem_full = mag_q - quot_x10;

  assign full   = (state_q != FS_IDLE);
  assign accept = push & ~full;

  assign q_push_o = (state_q == FS_PUSH) & ~q_full_i;

  always_comb begin
    q_data_o          = '0;
    q_data_o.neg      = neg_q;
    q_data_o.sign_en  = sign_en_q;
    q_data_o.pad_zero = pad_zero_q;
    q_data_o.nd       = nd_q;
    q_data_o.digits   = digits_q;
    q_data_o.pad_cnt  = (w_q > CntW'(nd_q)) ? w_q - CntW'(nd_q) : '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (accept) state_d = FS_CONV;
      FS_CONV: if (quot == 32'd0) state_d = FS_PUSH;
      FS_PUSH: if (!q_full_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q      <= mag_in;
      nd_q       <= '0;
      neg_q      <= neg;
      sign_en_q  <= sign_en;
      pad_zero_q <= (pad_mode_i == PAD_ZERO);
      w_q        <= w_in;
    end else if (state_q == FS_CONV) begin
      mag_q    <= quot;
      digits_q <= {digits_q[NumDigits-2:0], rem_full[3:0]};
      nd_q     <= nd_q + 1'b1;
    end
  end

endmodule

[rtl/pitd_back.sv]
module pitd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  pitd_pkg::desc_t q_data_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_char_o,
  output logic            last_char_o
);
  import pitd_pkg::*;

  localparam logic [1:0] PH_SIGN = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  logic               act_q, act_d;
  logic [1:0]         phase_q, phase_d;
  logic               neg_q, pad_zero_q;
  logic [CntW-1:0]    pad_cnt_q, pad_cnt_d;
  logic [DigCntW-1:0] nd_q, nd_d;
  digits_t            digits_q, digits_d;

  logic               out_vld_q, out_vld_d;
  logic [7:0]         out_char_q;
  logic               out_last_q;

  logic               emit;
  logic [7:0]         ch;
  logic               ch_last;
  logic               load;

  assign emit = act_q & (~out_vld_q | pop);

  always_comb begin
    phase_d   = phase_q;
    pad_cnt_d = pad_cnt_q;
    nd_d      = nd_q;
    digits_d  = digits_q;
    act_d     = act_q;
    ch        = CHAR_SPACE;
    ch_last   = 1'b0;
    unique case (phase_q)
      PH_SIGN: begin
        ch      = neg_q ? CHAR_MINUS : CHAR_SPACE;
        phase_d = (pad_cnt_q != '0) ? PH_PAD : PH_DIG;
      end
      PH_PAD: begin
        ch        = pad_zero_q ? CHAR_ZERO : CHAR_SPACE;
        pad_cnt_d = pad_cnt_q - 1'b1;
        if (pad_cnt_q == CntW'(1)) phase_d = PH_DIG;
      end
      default: begin
        ch       = CHAR_ZERO + {4'd0, digits_q[0]};
        ch_last  = (nd_q == DigCntW'(1));
        nd_d     = nd_q - 1'b1;
        digits_d = {4'd0, digits_q[NumDigits-1:1]};
      end
    endcase
    if (!emit) begin
      phase_d   = phase_q;
      pad_cnt_d = pad_cnt_q;
      nd_d      = nd_q;
      digits_d  = digits_q;
    end else if (ch_last) begin
      act_d = 1'b0;
    end
  end

  assign load    = (~act_q | (emit & ch_last)) & ~q_empty_i;
  assign q_pop_o = load;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      act_q     <= load | act_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q      <= q_data_i.neg;
      pad_zero_q <= q_data_i.pad_zero;
      pad_cnt_q  <= q_data_i.pad_cnt;
      nd_q       <= q_data_i.nd;
      digits_q   <= q_data_i.digits;
      if (q_data_i.sign_en) begin
        phase_q <= PH_SIGN;
      end else if (q_data_i.pad_cnt != '0) begin
        phase_q <= PH_PAD;
      end else begin
        phase_q <= PH_DIG;
      end
    end else begin
      phase_q   <= phase_d;
      pad_cnt_q <= pad_cnt_d;
      nd_q      <= nd_d;
      digits_q  <= digits_d;
    end
    if (emit) begin
      out_char_q <= ch;
      out_last_q <= ch_last;
    end
  end

  assign empty       = ~out_vld_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

[rtl/printf_integer_to_decimal_core.sv]
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// input     | push / full           | arg_value_i, signed_conv_i, size_mode_i,
//           |                       | pad_mode_i, min_width_i
// result    | empty / pop           | out_char_o, last_char_o (one char per beat)
//
// the front converts one number at a time (nd = 1..10 digits, one digit per
// cycle from a reciprocal multiply by ten), then hands it to a two-entry queue
// the back writes one char per cycle unless pop stalls; max(width, sign+nd) beats per
// number, 1 to max(MAX_WIDTH,11); only short fields wait on the front's conversion
// reset (rst_ni low) empties the queue and drops any number in flight
// pop low holds the current character; the front keeps converting until the
// queue is full, and full stays high while a number is being converted
module printf_integer_to_decimal_core #(
  parameter int unsigned MAX_WIDTH = pitd_pkg::MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [31:0] arg_value_i,
  input  logic        signed_conv_i,
  input  logic [1:0]  size_mode_i,
  input  logic [1:0]  pad_mode_i,
  input  logic [7:0]  min_width_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);
  import pitd_pkg::*;

  // converted numbers between front and back
  desc_t q_wdata, q_rdata;
  logic  q_push, q_full, q_pop, q_empty;

  // front: narrows, signs and clamps the field, then peels off decimal digits
  pitd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .arg_value_i   (arg_value_i),
    .signed_conv_i (signed_conv_i),
    .size_mode_i   (size_mode_i),
    .pad_mode_i    (pad_mode_i),
    .min_width_i   (min_width_i),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata),
    .q_full_i      (q_full)
  );

  // short queue so conversion of the next number overlaps output of this one
  pitd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // back: sign, pad, then digits msd first, into a registered output stage
  pitd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule
